### src/sadq_pkg.sv
// Shared types and constants for the sorted alarm deadline queue.
// No dependencies; every other file imports this package.
`default_nettype none

package sadq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 8;

    localparam int DEADLINE_W  = 32;
    localparam int DELAY_W     = 16;
    localparam int TAG_FIELD_W = 8;
    localparam int RES_W       = 2;

    localparam logic [RES_W-1:0] RES_ACCEPT  = 2'd0;
    localparam logic [RES_W-1:0] RES_FULL    = 2'd1;
    localparam logic [RES_W-1:0] RES_EXPIRED = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_INSERT = 3'b010,
        ST_DRAIN  = 3'b100
    } state_t;

endpackage

`default_nettype wire

### src/sorted_alarm_deadline_queue.sv
// Sorted alarm deadline queue: a chain of QUEUE_DEPTH cells kept in deadline order.
// Add: the alarm is latched on accept; in ST_INSERT, once the output is free, the result registers
// and the alarm is inserted into the chain by a shift right (RES_FULL if full). Tick: in ST_DRAIN,
// each expiry is a pop of the head cell, one per cycle unless out stalls. One item in work at a time:
// the next item is accepted only back in ST_IDLE, after an add's result or once a tick has nothing due.
// Reset (rst_n, async, active low) clears the tick counter, all valid bits and out_valid.
`default_nettype none

module sorted_alarm_deadline_queue
    import sadq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   kind,
    input  wire logic [DELAY_W-1:0]     delay_seconds,
    input  wire logic [TAG_FIELD_W-1:0] alarm_tag,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [RES_W-1:0]            event_res,
    output logic [TAG_FIELD_W-1:0]      out_tag,
    output logic [DELAY_W-1:0]          out_delay,
    output logic [DEADLINE_W-1:0]       out_deadline,
    output logic                        last
);

    // Only the low bits of the tag that also fit the result field are ever visible.
    localparam int TAG_W = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;

    state_t state_reg, state_next;

    logic [DEADLINE_W-1:0] now_reg, now_next;

    // Alarm being added, held from accept to insert.
    logic [DEADLINE_W-1:0] add_deadline_reg, add_deadline_next;
    logic [TAG_W-1:0]      add_tag_reg, add_tag_next;
    logic [DELAY_W-1:0]    add_delay_reg, add_delay_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [RES_W-1:0]       res_reg, res_next;
    logic [TAG_W-1:0]       otag_reg, otag_next;
    logic [DELAY_W-1:0]     odelay_reg, odelay_next;
    logic [DEADLINE_W-1:0]  odeadline_reg, odeadline_next;
    logic                   last_reg, last_next;

    // Chain taps.
    logic                  c_valid    [QUEUE_DEPTH];
    logic                  c_ge       [QUEUE_DEPTH];
    logic [DEADLINE_W-1:0] c_deadline [QUEUE_DEPTH];
    logic [TAG_W-1:0]      c_tag      [QUEUE_DEPTH];
    logic [DELAY_W-1:0]    c_delay    [QUEUE_DEPTH];

    cell_cmd_t cmd;

    logic                  slot_free;
    logic                  queue_full;
    logic                  head_due;
    logic                  next_due;
    logic [DEADLINE_W:0]   sum_wide;
    logic [DEADLINE_W-1:0] sum_sat;
    logic [TAG_FIELD_W-1:0] tag_ext;

    assign slot_free  = !out_valid_reg || out_ready;
    assign queue_full = c_valid[QUEUE_DEPTH-1];
    assign head_due   = c_valid[0] && (c_deadline[0] <= now_reg);
    assign next_due   = c_valid[1] && (c_deadline[1] <= now_reg);

    // Deadline is now plus delay, clamped at the top of the tick range.
    assign sum_wide = {1'b0, now_reg} + {{(DEADLINE_W + 1 - DELAY_W){1'b0}}, delay_seconds};
    assign sum_sat  = sum_wide[DEADLINE_W] ? {DEADLINE_W{1'b1}} : sum_wide[DEADLINE_W-1:0];

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        now_next          = now_reg;
        add_deadline_next = add_deadline_reg;
        add_tag_next      = add_tag_reg;
        add_delay_next    = add_delay_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        res_next          = res_reg;
        otag_next         = otag_reg;
        odelay_next       = odelay_reg;
        odeadline_next    = odeadline_reg;
        last_next         = last_reg;
        cmd               = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind)
                    begin
                        // latch the alarm with its deadline against the current time
                        add_deadline_next = sum_sat;
                        add_tag_next      = alarm_tag[TAG_W-1:0];
                        add_delay_next    = delay_seconds;
                        state_next        = ST_INSERT;
                    end
                    else
                    begin
                        // advance time, holding at the top value
                        if (now_reg != {DEADLINE_W{1'b1}})
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_INSERT:
            begin
                if (slot_free)
                begin
                    cmd.insert     = !queue_full;
                    out_valid_next = 1'b1;
                    res_next       = queue_full ? RES_FULL : RES_ACCEPT;
                    otag_next      = add_tag_reg;
                    odelay_next    = add_delay_reg;
                    odeadline_next = add_deadline_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (!head_due)
                begin
                    // nothing (more) due: no result
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    // emit the head and pop the chain left by one
                    cmd.pop        = 1'b1;
                    out_valid_next = 1'b1;
                    res_next       = RES_EXPIRED;
                    otag_next      = c_tag[0];
                    odelay_next    = c_delay[0];
                    odeadline_next = c_deadline[0];
                    last_next      = !next_due;
                    if (!next_due)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                  p_ge;
            logic                  p_valid;
            logic [DEADLINE_W-1:0] p_deadline;
            logic [TAG_W-1:0]      p_tag;
            logic [DELAY_W-1:0]    p_delay;
            logic                  s_valid;
            logic [DEADLINE_W-1:0] s_deadline;
            logic [TAG_W-1:0]      s_tag;
            logic [DELAY_W-1:0]    s_delay;

            if (gi == 0)
            begin : g_head
                // the head sees an always-valid, never-later neighbor ahead of it
                assign p_ge       = 1'b0;
                assign p_valid    = 1'b1;
                assign p_deadline = '0;
                assign p_tag      = '0;
                assign p_delay    = '0;
            end
            else
            begin : g_body
                assign p_ge       = c_ge[gi-1];
                assign p_valid    = c_valid[gi-1];
                assign p_deadline = c_deadline[gi-1];
                assign p_tag      = c_tag[gi-1];
                assign p_delay    = c_delay[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign s_valid    = 1'b0;
                assign s_deadline = '0;
                assign s_tag      = '0;
                assign s_delay    = '0;
            end
            else
            begin : g_inner
                assign s_valid    = c_valid[gi+1];
                assign s_deadline = c_deadline[gi+1];
                assign s_tag      = c_tag[gi+1];
                assign s_delay    = c_delay[gi+1];
            end

            sadq_cell #(
                .TAG_W (TAG_W)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd),
                .new_deadline  (add_deadline_reg),
                .new_tag       (add_tag_reg),
                .new_delay     (add_delay_reg),
                .prev_ge       (p_ge),
                .prev_valid    (p_valid),
                .prev_deadline (p_deadline),
                .prev_tag      (p_tag),
                .prev_delay    (p_delay),
                .succ_valid    (s_valid),
                .succ_deadline (s_deadline),
                .succ_tag      (s_tag),
                .succ_delay    (s_delay),
                .valid         (c_valid[gi]),
                .ge            (c_ge[gi]),
                .deadline      (c_deadline[gi]),
                .tag           (c_tag[gi]),
                .delay         (c_delay[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_deadline_reg <= add_deadline_next;
        add_tag_reg      <= add_tag_next;
        add_delay_reg    <= add_delay_next;
        res_reg          <= res_next;
        otag_reg         <= otag_next;
        odelay_reg       <= odelay_next;
        odeadline_reg    <= odeadline_next;
        last_reg         <= last_next;
    end

    // Zero-extend the stored tag to the result field.
    always_comb
    begin
        tag_ext            = '0;
        tag_ext[TAG_W-1:0] = otag_reg;
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = res_reg;
    assign out_tag      = tag_ext;
    assign out_delay    = odelay_reg;
    assign out_deadline = odeadline_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### src/sadq_cell.sv
// One slot of the sorted alarm chain: valid bit, deadline, tag and delay.
// Depends on sadq_pkg; instantiated by sorted_alarm_deadline_queue.
`default_nettype none

module sadq_cell
    import sadq_pkg::*;
#(
    parameter int TAG_W = TAG_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_cmd_t             cmd,
    input  wire logic [DEADLINE_W-1:0] new_deadline,
    input  wire logic [TAG_W-1:0]      new_tag,
    input  wire logic [DELAY_W-1:0]    new_delay,
    input  wire logic                  prev_ge,
    input  wire logic                  prev_valid,
    input  wire logic [DEADLINE_W-1:0] prev_deadline,
    input  wire logic [TAG_W-1:0]      prev_tag,
    input  wire logic [DELAY_W-1:0]    prev_delay,
    input  wire logic                  succ_valid,
    input  wire logic [DEADLINE_W-1:0] succ_deadline,
    input  wire logic [TAG_W-1:0]      succ_tag,
    input  wire logic [DELAY_W-1:0]    succ_delay,
    output logic                       valid,
    output logic                       ge,
    output logic [DEADLINE_W-1:0]      deadline,
    output logic [TAG_W-1:0]           tag,
    output logic [DELAY_W-1:0]         delay
);

    logic                  valid_reg, valid_next;
    logic [DEADLINE_W-1:0] deadline_reg, deadline_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [DELAY_W-1:0]    delay_reg, delay_next;

    assign ge = valid_reg && (deadline_reg >= new_deadline);

    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        delay_next    = delay_reg;
        if (cmd.insert)
        begin
            if (prev_ge)
            begin
                // shift right: the new alarm lands ahead of us
                valid_next    = 1'b1;
                deadline_next = prev_deadline;
                tag_next      = prev_tag;
                delay_next    = prev_delay;
            end
            else if (ge || (!valid_reg && prev_valid))
            begin
                valid_next    = 1'b1;
                deadline_next = new_deadline;
                tag_next      = new_tag;
                delay_next    = new_delay;
            end
        end
        else if (cmd.pop)
        begin
            valid_next    = succ_valid;
            deadline_next = succ_deadline;
            tag_next      = succ_tag;
            delay_next    = succ_delay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
        delay_reg    <= delay_next;
    end

    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign tag      = tag_reg;
    assign delay    = delay_reg;

endmodule

`default_nettype wire
